// ===== rtl/core/bdd_pkg.sv =====
// Package for the height-map to du/dv bump converter.
// Holds the payload structs, register codes and fixed constants; no dependencies.
`default_nettype none

package bdd_pkg;

	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;
	localparam int WIDTH_REG_BITS = 12;
	localparam int HEIGHT_REG_BITS = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd256;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd256;
	localparam logic [HEIGHT_REG_BITS-1:0] MAX_HEIGHT   = 13'd4096;

	// floor(s / 3) = (s * 683) >> 11 holds for every s up to 765.
	localparam logic [9:0] DIV3_MUL   = 10'd683;
	localparam int         DIV3_SHIFT = 11;

	localparam logic [7:0] LUMA_FULL = 8'hFF;

	typedef struct packed {
		logic       pixel_present;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] delta_u;
		logic [7:0] delta_v;
		logic [7:0] luminance;
		logic       frame_end;
	} bump_t;

endpackage

`default_nettype wire

// ===== rtl/core/bump_dudv_from_heightmap.sv =====
// Height-map to du/dv bump converter, top level. Uses bdd_pkg and bdd_window.
// Throughput: one beat per cycle unless the output stalls, set by the single read-first port
// of each line buffer. The result for a pixel is produced once width+1 more items are taken,
// is registered in stage 1 and then loaded into the output register unless the output stalls.
// Reset: positions cleared, width and height 256; line buffers are not cleared.
`default_nettype none

module bump_dudv_from_heightmap #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pix_valid,
	output logic                                  pix_ready,
	input  wire bdd_pkg::pixel_t                  pix,
	output logic                                  bump_valid,
	input  wire logic                             bump_ready,
	output bdd_pkg::bump_t                        bump,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HB = bdd_pkg::HEIGHT_REG_BITS;

	function automatic logic [WW-1:0] sat_width(
		input logic [bdd_pkg::WIDTH_REG_BITS-1:0] raw
	);
		logic [WW-1:0] res;
		if (raw == '0) begin
			res = WW'(1);
		end else if (32'(raw) > MAX_WIDTH) begin
			res = WW'(MAX_WIDTH);
		end else begin
			res = WW'(raw);
		end
		return res;
	endfunction

	function automatic logic [HB-1:0] sat_height(input logic [HB-1:0] raw);
		logic [HB-1:0] res;
		if (raw == '0) begin
			res = HB'(1);
		end else if (raw > bdd_pkg::MAX_HEIGHT) begin
			res = bdd_pkg::MAX_HEIGHT;
		end else begin
			res = raw;
		end
		return res;
	endfunction

	logic [WW-1:0] width_q;
	logic [HB-1:0] height_q;
	logic [CW-1:0] icol_q;
	logic [HB-1:0] irow_q;
	logic [CW-1:0] ocol_q;
	logic [11:0]   orow_q;

	logic cfg_hit;
	logic pix_acc, in_frame, counted, emit_now, last_now;
	logic out_free;
	logic [CW:0] w_ext, icol_inc, ocol_inc;
	logic [HB-1:0] orow_inc;
	logic icol_wrap, ocol_wrap, emit_pos;
	logic [9:0] rgb_sum;
	logic [19:0] div_prod;
	logic [7:0] hgt;

	logic [7:0] rd_a, rd_b;
	logic [7:0] h_q, b_q, c_q, l_q;

	logic valid_s1, lft_ok_s1, rgt_ok_s1, up_ok_s1, dn_ok_s1, last_s1;
	logic bump_valid_q;
	bdd_pkg::bump_t bump_q;

	logic [7:0] nb_l, nb_r, nb_a, nb_b, du, dv;
	logic valley;

	assign cfg_ready = 1'b1;
	assign cfg_hit = cfg_valid && (cfg_index == bdd_pkg::REG_IMAGE_WIDTH
		|| cfg_index == bdd_pkg::REG_IMAGE_HEIGHT);

	assign out_free  = !bump_valid_q || bump_ready;
	assign pix_ready = !valid_s1 || out_free;
	assign pix_acc   = pix_valid && pix_ready;

	assign in_frame = irow_q < height_q;
	// A gap beat inside the frame is taken and dropped; after the frame every beat
	// counts as flush.
	assign counted  = pix_acc && (pix.pixel_present || !in_frame);

	assign rgb_sum  = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
	assign div_prod = 20'(rgb_sum) * 20'(bdd_pkg::DIV3_MUL);
	assign hgt      = in_frame ? 8'(div_prod >> bdd_pkg::DIV3_SHIFT) : 8'd0;

	assign w_ext     = (CW + 1)'(width_q);
	assign icol_inc  = (CW + 1)'(icol_q) + 1'b1;
	assign icol_wrap = icol_inc >= w_ext;
	assign ocol_inc  = (CW + 1)'(ocol_q) + 1'b1;
	assign ocol_wrap = ocol_inc == w_ext;
	assign orow_inc  = HB'(orow_q) + 1'b1;

	// At least width+1 items precede this one in the frame.
	assign emit_pos = (irow_q >= HB'(2)) || (irow_q == HB'(1) && icol_q != '0);
	assign emit_now = counted && emit_pos;
	assign last_now = emit_now && ocol_wrap && (orow_inc == height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sat_width(bdd_pkg::WIDTH_RESET);
			height_q <= sat_height(bdd_pkg::HEIGHT_RESET);
		end else if (cfg_valid) begin
			if (cfg_index == bdd_pkg::REG_IMAGE_WIDTH) begin
				width_q <= sat_width(cfg_data[bdd_pkg::WIDTH_REG_BITS-1:0]);
			end
			if (cfg_index == bdd_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= sat_height(cfg_data[HB-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_hit || last_now) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (counted) begin
			if (icol_wrap) begin
				icol_q <= '0;
				irow_q <= irow_q + 1'b1;
			end else begin
				icol_q <= CW'(icol_inc);
			end
			if (emit_now) begin
				if (ocol_wrap) begin
					ocol_q <= '0;
					orow_q <= 12'(orow_inc);
				end else begin
					ocol_q <= CW'(ocol_inc);
				end
			end
		end
	end

	// Line A delays heights by one row; line B delays the centre stream by one row.
	bdd_window #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW)
	) u_window (
		.clk (clk),
		.en  (counted),
		.addr(icol_q),
		.wr_a(hgt),
		.wr_b(rd_a),
		.rd_a(rd_a),
		.rd_b(rd_b)
	);

	always_ff @(posedge clk) begin
		if (counted) begin
			h_q <= hgt;
			b_q <= h_q;
			c_q <= rd_a;
			l_q <= c_q;
			lft_ok_s1 <= ocol_q != '0;
			rgt_ok_s1 <= ocol_inc < w_ext;
			up_ok_s1  <= orow_q != '0;
			dn_ok_s1  <= orow_inc < height_q;
			last_s1   <= last_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (counted) begin
			valid_s1 <= emit_now;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		nb_l = lft_ok_s1 ? l_q : c_q;
		nb_r = rgt_ok_s1 ? rd_a : c_q;
		nb_a = up_ok_s1 ? rd_b : c_q;
		nb_b = dn_ok_s1 ? b_q : c_q;
		valley = (c_q < nb_l) && (c_q < nb_r);
		// In a valley left-centre is positive and centre-right negative, so the
		// larger of the two is always left-centre.
		du = valley ? (nb_l - c_q) : (nb_l - nb_r);
		dv = nb_a - nb_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_valid_q <= 1'b0;
		end else if (out_free) begin
			bump_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			bump_q.delta_u   <= du;
			bump_q.delta_v   <= dv;
			bump_q.luminance <= bdd_pkg::LUMA_FULL;
			bump_q.frame_end <= last_s1;
		end
	end

	assign bump_valid = bump_valid_q;
	assign bump       = bump_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdd_window.sv =====
// Two line buffers of heights, one row deep each, with registered read-first ports.
// Used by bump_dudv_from_heightmap; no package dependencies.
`default_nettype none

module bdd_window #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wr_a,
	input  wire logic [7:0]    wr_b,
	output logic      [7:0]    rd_a,
	output logic      [7:0]    rd_b
);

	logic [7:0] line_a [DEPTH];
	logic [7:0] line_b [DEPTH];

	// Read returns the entry as it was before this beat's write, so a width of
	// one needs no forwarding.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_a <= line_a[addr];
			line_a[addr] <= wr_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_b <= line_b[addr];
			line_b[addr] <= wr_b;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bdd_checker.sv =====
// Port-level checks for bump_dudv_from_heightmap, attached by the bind at the end.
// Depends on bdd_pkg for the payload types.
`default_nettype none

module bdd_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            pix_valid,
	input wire logic            pix_ready,
	input wire bdd_pkg::bump_t  bump,
	input wire logic            bump_valid,
	input wire logic            bump_ready
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bump_valid && !bump_ready |=> bump_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		bump_valid && !bump_ready |=> $stable(bump))
		else $error("result payload changed while stalled");

	// With the output register empty the pipeline can always take a pixel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!bump_valid |-> pix_ready)
		else $error("input stalled with empty output");

	a_luma: assert property (@(posedge clk) disable iff (!arst_n)
		bump_valid |-> bump.luminance == bdd_pkg::LUMA_FULL)
		else $error("luminance not full scale");

	// Input can only be stalled when a result is waiting and not being taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |-> bump_valid && !bump_ready)
		else $error("input stalled without output back-pressure");

endmodule

bind bump_dudv_from_heightmap bdd_checker u_bdd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.bump      (bump),
	.bump_valid(bump_valid),
	.bump_ready(bump_ready)
);

`default_nettype wire
